// ===== src/elbu_pkg.sv =====
package elbu_pkg;

   // fixed field widths of the channel words
   localparam int ACTION_W = 2;
   localparam int SLOT_W   = 11;
   localparam int NODE_W   = 10;
   localparam int VALUE_W  = 31;
   localparam int LOAD_W   = 31;
   localparam int WOUT_W   = 17;

   localparam int NODE_COUNT_DEF    = 1024;
   localparam int EDGE_COUNT_DEF    = 1024;
   localparam int FRACTION_BITS_DEF = 16;

   typedef enum logic [ACTION_W-1:0] {
      ACT_WRITE_EDGE = 2'd0,
      ACT_WRITE_LOAD = 2'd1,
      ACT_UPDATE     = 2'd2,
      ACT_READ_LOAD  = 2'd3
   } action_type;

   typedef struct packed {
      action_type          action;
      logic [SLOT_W-1:0]   slot;
      logic [NODE_W-1:0]   node;
      logic [VALUE_W-1:0]  value;
   } req_word_type;

   typedef struct packed {
      logic [LOAD_W-1:0]   read_load;
      logic [WOUT_W-1:0]   first_weight;
      logic [WOUT_W-1:0]   second_weight;
      logic                saturated;
   } rsp_word_type;

   // address bits for a table of the given depth, at least one
   function automatic int addr_width(input int depth);
      return (depth > 1) ? $clog2(depth) : 1;
   endfunction

endpackage

// ===== src/elbu_chan_if.sv =====
interface elbu_chan_if #(parameter type word_type = logic);

   logic     valid;
   logic     ready;
   word_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);

endinterface

// ===== src/elbu_ram.sv =====
module elbu_ram #(
   parameter int WIDTH = elbu_pkg::LOAD_W,
   parameter int DEPTH = elbu_pkg::NODE_COUNT_DEF
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [elbu_pkg::addr_width(DEPTH)-1:0]   wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic [elbu_pkg::addr_width(DEPTH)-1:0]   rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);
   import elbu_pkg::*;

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/edge_load_balancing_update_core.sv =====
// Edge load balancing update core. Holds the endpoint and Q1.16 weight of every edge half
// (even and odd halves in two banks, so both halves of an edge come out in one read) and the
// Q15.16 load of every node (two copies of one table, giving two read ports). Each request
// word gives exactly one response word. An update steps through edge read, two load reads,
// difference and clamp, then the two load write-backs, which share the single load write port
// and so run one after the other; the second adjustment sees the first one's result when both
// halves end on the same node. A table write goes straight from acceptance to the done state,
// and a load read passes through its read state first; every word loads the response register
// in the done state. One word is in flight at a time; a new word is taken while the previous
// response still waits in the output register, and a response still held there keeps the next
// word in its done state until it is taken.
module edge_load_balancing_update_core #(
   parameter int NODE_COUNT    = elbu_pkg::NODE_COUNT_DEF,
   parameter int EDGE_COUNT    = elbu_pkg::EDGE_COUNT_DEF,
   parameter int FRACTION_BITS = elbu_pkg::FRACTION_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   elbu_chan_if.sink   req_ch,
   elbu_chan_if.source rsp_ch
);
   import elbu_pkg::*;

   localparam int NW    = addr_width(NODE_COUNT);
   localparam int EW    = addr_width(EDGE_COUNT);
   localparam int WW    = FRACTION_BITS + 1;
   localparam int ENT_W = NW + WW;
   localparam int SUM_W = 34;

   localparam logic [WW-1:0]           ONE_W    = WW'(1) << FRACTION_BITS;
   localparam logic signed [SUM_W-1:0] ONE_S    = SUM_W'(ONE_W);
   localparam logic signed [SUM_W-1:0] LOAD_MAX = SUM_W'({LOAD_W{1'b1}});

   typedef enum logic [2:0] {
      ST_IDLE, ST_EDGE_RD, ST_LOAD_RD, ST_CALC, ST_ADJ_U, ST_ADJ_V, ST_READ, ST_DONE
   } state_type;

   state_type          state_ff;
   logic               rsp_valid_ff;
   rsp_word_type       rsp_data_ff;
   rsp_word_type       res_ff;
   logic               rd_ok_ff;
   logic [EW-1:0]      e_ff;
   logic [NW-1:0]      eu_ff, ev_ff;
   logic [WW-1:0]      wu_ff, wv_ff;
   logic [LOAD_W-1:0]  lu_ff, lv_ff;
   logic [WW-1:0]      nf_ff, ns_ff;
   logic [LOAD_W-1:0]  new_lu_ff;
   logic               clip_u_ff;

   req_word_type       req_w;
   logic               req_fire;
   logic               node_ok, half_ok, edge_ok;
   logic [WW-1:0]      wr_weight;

   logic               even_we, odd_we;
   logic [EW-1:0]      edge_waddr, edge_raddr;
   logic [ENT_W-1:0]   even_wdata, odd_wdata, even_rd, odd_rd;
   logic               ld_we;
   logic [NW-1:0]      ld_waddr, lda_raddr, ldb_raddr;
   logic [LOAD_W-1:0]  ld_wdata, lda_rd, ldb_rd;

   logic [NW-1:0]            u_addr, v_addr;
   logic signed [SUM_W-1:0]  d_in, mid_in, sum_u_in, sum_v_in;
   logic [WW-1:0]            nf_in, ns_in;
   logic [LOAD_W-1:0]        base_v_in, new_lu_in, new_lv_in;
   logic                     clip_u_in, clip_v_in;

   assign req_w    = req_ch.payload;
   assign req_fire = req_ch.valid && req_ch.ready;
   assign req_ch.ready = (state_ff == ST_IDLE);

   assign node_ok = 32'(req_w.node) < NODE_COUNT;
   assign half_ok = 32'(req_w.slot) < 2 * EDGE_COUNT;
   assign edge_ok = 32'(req_w.slot) < EDGE_COUNT;

   assign wr_weight = (33'(req_w.value) > 33'(ONE_W)) ? ONE_W : WW'(req_w.value);

   // a stored endpoint beyond the node range maps to node zero
   assign u_addr = (32'(eu_ff) < NODE_COUNT) ? eu_ff : '0;
   assign v_addr = (32'(ev_ff) < NODE_COUNT) ? ev_ff : '0;

   // new weights from the loads just read
   always_comb begin
      d_in   = (SUM_W'(wu_ff) + SUM_W'(ldb_rd)) - (SUM_W'(wv_ff) + SUM_W'(lda_rd));
      mid_in = (d_in + ONE_S) >>> 1;
      if (d_in < -ONE_S) begin
         nf_in = '0;
      end else if (d_in > ONE_S) begin
         nf_in = ONE_W;
      end else begin
         nf_in = WW'(mid_in);
      end
      ns_in = ONE_W - nf_in;
   end

   // saturating load adjustments; same node forwards the first result
   always_comb begin
      sum_u_in  = SUM_W'(lu_ff) + SUM_W'(nf_ff) - SUM_W'(wu_ff);
      clip_u_in = 1'b0;
      new_lu_in = LOAD_W'(sum_u_in);
      if (sum_u_in < 0) begin
         new_lu_in = '0;
         clip_u_in = 1'b1;
      end else if (sum_u_in > LOAD_MAX) begin
         new_lu_in = LOAD_W'(LOAD_MAX);
         clip_u_in = 1'b1;
      end

      base_v_in = (u_addr == v_addr) ? new_lu_ff : lv_ff;
      sum_v_in  = SUM_W'(base_v_in) + SUM_W'(ns_ff) - SUM_W'(wv_ff);
      clip_v_in = 1'b0;
      new_lv_in = LOAD_W'(sum_v_in);
      if (sum_v_in < 0) begin
         new_lv_in = '0;
         clip_v_in = 1'b1;
      end else if (sum_v_in > LOAD_MAX) begin
         new_lv_in = LOAD_W'(LOAD_MAX);
         clip_v_in = 1'b1;
      end
   end

   // memory port control
   always_comb begin
      even_we    = 1'b0;
      odd_we     = 1'b0;
      edge_waddr = e_ff;
      edge_raddr = EW'(req_w.slot);
      even_wdata = {eu_ff, nf_ff};
      odd_wdata  = {ev_ff, ns_ff};
      ld_we      = 1'b0;
      ld_waddr   = u_addr;
      ld_wdata   = new_lu_in;
      lda_raddr  = NW'(req_w.node);
      ldb_raddr  = v_addr;
      case (state_ff)
         ST_IDLE: begin
            edge_waddr = EW'(req_w.slot >> 1);
            even_wdata = {NW'(req_w.node), wr_weight};
            odd_wdata  = {NW'(req_w.node), wr_weight};
            if (req_fire && req_w.action == ACT_WRITE_EDGE && half_ok && node_ok) begin
               even_we = !req_w.slot[0];
               odd_we  = req_w.slot[0];
            end
            ld_waddr = NW'(req_w.node);
            ld_wdata = LOAD_W'(req_w.value);
            ld_we    = req_fire && req_w.action == ACT_WRITE_LOAD && node_ok;
         end
         ST_LOAD_RD: begin
            lda_raddr = u_addr;
         end
         ST_ADJ_U: begin
            even_we = 1'b1;
            odd_we  = 1'b1;
            ld_we   = 1'b1;
         end
         ST_ADJ_V: begin
            ld_we    = 1'b1;
            ld_waddr = v_addr;
            ld_wdata = new_lv_in;
         end
         default: ;
      endcase
   end

   elbu_ram #(.WIDTH(ENT_W), .DEPTH(EDGE_COUNT)) u_even_bank (
      .clock   (clock),
      .wr_en   (even_we),
      .wr_addr (edge_waddr),
      .wr_data (even_wdata),
      .rd_addr (edge_raddr),
      .rd_data (even_rd)
   );

   elbu_ram #(.WIDTH(ENT_W), .DEPTH(EDGE_COUNT)) u_odd_bank (
      .clock   (clock),
      .wr_en   (odd_we),
      .wr_addr (edge_waddr),
      .wr_data (odd_wdata),
      .rd_addr (edge_raddr),
      .rd_data (odd_rd)
   );

   // two copies of the load table, written together
   elbu_ram #(.WIDTH(LOAD_W), .DEPTH(NODE_COUNT)) u_load_a (
      .clock   (clock),
      .wr_en   (ld_we),
      .wr_addr (ld_waddr),
      .wr_data (ld_wdata),
      .rd_addr (lda_raddr),
      .rd_data (lda_rd)
   );

   elbu_ram #(.WIDTH(LOAD_W), .DEPTH(NODE_COUNT)) u_load_b (
      .clock   (clock),
      .wr_en   (ld_we),
      .wr_addr (ld_waddr),
      .wr_data (ld_wdata),
      .rd_addr (ldb_raddr),
      .rd_data (ldb_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         // in ST_DONE the valid flag is set below whenever the register can take a word
         if (rsp_ch.ready && state_ff != ST_DONE) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  res_ff   <= '0;
                  e_ff     <= EW'(req_w.slot);
                  rd_ok_ff <= node_ok;
                  case (req_w.action)
                     ACT_UPDATE:    state_ff <= edge_ok ? ST_EDGE_RD : ST_DONE;
                     ACT_READ_LOAD: state_ff <= ST_READ;
                     default:       state_ff <= ST_DONE;
                  endcase
               end
            end
            ST_EDGE_RD: begin
               eu_ff    <= even_rd[ENT_W-1:WW];
               wu_ff    <= even_rd[WW-1:0];
               ev_ff    <= odd_rd[ENT_W-1:WW];
               wv_ff    <= odd_rd[WW-1:0];
               state_ff <= ST_LOAD_RD;
            end
            ST_LOAD_RD: begin
               state_ff <= ST_CALC;
            end
            ST_CALC: begin
               lu_ff    <= lda_rd;
               lv_ff    <= ldb_rd;
               nf_ff    <= nf_in;
               ns_ff    <= ns_in;
               state_ff <= ST_ADJ_U;
            end
            ST_ADJ_U: begin
               new_lu_ff <= new_lu_in;
               clip_u_ff <= clip_u_in;
               state_ff  <= ST_ADJ_V;
            end
            ST_ADJ_V: begin
               res_ff.first_weight  <= WOUT_W'(nf_ff);
               res_ff.second_weight <= WOUT_W'(ns_ff);
               res_ff.saturated     <= clip_u_ff || clip_v_in;
               state_ff             <= ST_DONE;
            end
            ST_READ: begin
               res_ff.read_load <= rd_ok_ff ? lda_rd : '0;
               state_ff         <= ST_DONE;
            end
            ST_DONE: begin
               if (!rsp_valid_ff || rsp_ch.ready) begin
                  rsp_data_ff  <= res_ff;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.payload = rsp_data_ff;

endmodule
